### design/rhr_pkg.sv
package rhr_pkg;

    // Pixel channel width.
    localparam int CH_W = 8;

    // Fractions of one are 16-bit, one turn of hue is 65536.
    localparam int FRAC_W = 16;

    // Reset value of the hue step register.
    localparam logic [FRAC_W-1:0] HUE_STEP_RESET = 16'd3277;

    // One third of a turn.
    localparam logic [FRAC_W-1:0] THIRD_TURN = 16'd21845;

    // Fraction divider: operands up to 6 * 255, quotient of (a << 16) / b with a <= b.
    localparam int DIV_W           = 11;
    localparam int QUOT_W          = FRAC_W + 1;
    localparam int DIV_STEPS       = 4;
    localparam int DIV_STAGES      = (QUOT_W + DIV_STEPS - 1) / DIV_STEPS;

    // Lightness = floor(sum * 32768 / 255) = (sum * L_RECIP) >> L_SHIFT, exact for sum <= 510.
    localparam int               SUM_W   = CH_W + 1;
    localparam int               RECIP_W = 25;
    localparam logic [RECIP_W-1:0] L_RECIP = 25'd16843010;
    localparam int               L_SHIFT = 17;

    // Result of the first stage: channel analysis.
    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic             grey;
        logic [SUM_W-1:0] sum;
        logic [DIV_W-1:0] hue_num;
        logic [DIV_W-1:0] hue_den;
        logic [DIV_W-1:0] sat_num;
        logic [DIV_W-1:0] sat_den;
    } ana_t;

    // Data that travels beside the dividers.
    typedef struct packed {
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic              grey;
        logic [FRAC_W-1:0] light;
    } side_t;

endpackage

### design/rgb_hue_rotate_via_hsl_unit.sv
// Hue rotation of an 8-bit RGB pixel stream through HSL space. Each pixel is
// turned into hue, saturation and lightness as 16-bit fractions, the hue step
// register (cfg_write_data, taken when cfg_write_en is high, reset value 3277
// in units of 1/65536 turn) is added to the hue with wrap-around, and the pixel is rebuilt
// with the usual piecewise hue-to-RGB rule, each channel truncated and clamped
// to 0..255. Grey pixels pass through unchanged. The block takes one item in every
// cycle while the output is not stalled, and passes it through channel analysis,
// the two fraction dividers (17 quotient bits, four per stage) and rebuilding,
// each of them registered. A stall on the output freezes the whole pipeline,
// so in_stall follows out_stall while an item waits at the output. The hue step
// must only be written while no item is in flight.
module rgb_hue_rotate_via_hsl_unit
    import rhr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [FRAC_W-1:0] cfg_write_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CH_W-1:0]   red_in,
    input  logic [CH_W-1:0]   green_in,
    input  logic [CH_W-1:0]   blue_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CH_W-1:0]   red_out,
    output logic [CH_W-1:0]   green_out,
    output logic [CH_W-1:0]   blue_out
);

    logic              en;
    logic [FRAC_W-1:0] hue_step_reg;
    logic              ana_valid;
    ana_t              ana;
    logic [QUOT_W-1:0] sat_quot;
    logic [QUOT_W-1:0] hue_quot;
    logic              side_valid_reg [DIV_STAGES];
    side_t             side_reg       [DIV_STAGES];
    side_t             side_next;
    logic [SUM_W+RECIP_W-1:0] light_prod;

    // The pipeline moves whenever the output register is free or being taken.
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_step_reg <= HUE_STEP_RESET;
        end
        else if (cfg_write_en)
        begin
            hue_step_reg <= cfg_write_data;
        end
    end

    rhr_analyze u_analyze (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (in_valid),
        .red       (red_in),
        .green     (green_in),
        .blue      (blue_in),
        .ana_valid (ana_valid),
        .ana       (ana)
    );

    rhr_divider u_sat_div (
        .clk  (clk),
        .en   (en),
        .num  (ana.sat_num),
        .den  (ana.sat_den),
        .quot (sat_quot)
    );

    rhr_divider u_hue_div (
        .clk  (clk),
        .en   (en),
        .num  (ana.hue_num),
        .den  (ana.hue_den),
        .quot (hue_quot)
    );

    // Lightness is worked out by reciprocal multiplication as the item enters
    // the side line that runs beside the dividers.
    always_comb
    begin
        light_prod      = (SUM_W+RECIP_W)'(ana.sum) * (SUM_W+RECIP_W)'(L_RECIP);
        side_next.red   = ana.red;
        side_next.green = ana.green;
        side_next.blue  = ana.blue;
        side_next.grey  = ana.grey;
        side_next.light = light_prod[L_SHIFT+FRAC_W-1:L_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                side_valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            side_valid_reg[0] <= ana_valid;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                side_valid_reg[i] <= side_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    rhr_rebuild u_rebuild (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (side_valid_reg[DIV_STAGES-1]),
        .side      (side_reg[DIV_STAGES-1]),
        .sat_quot  (sat_quot),
        .hue_quot  (hue_quot),
        .hue_step  (hue_step_reg),
        .out_valid (out_valid),
        .red       (red_out),
        .green     (green_out),
        .blue      (blue_out)
    );

endmodule

### design/rhr_divider.sv
module rhr_divider
    import rhr_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DIV_W-1:0]  num,
    input  logic [DIV_W-1:0]  den,
    output logic [QUOT_W-1:0] quot
);

    // Restoring division, up to DIV_STEPS quotient bits per register stage.
    logic [DIV_W-1:0]  rem_reg  [DIV_STAGES];
    logic [DIV_W-1:0]  den_reg  [DIV_STAGES];
    logic [QUOT_W-1:0] quot_reg [DIV_STAGES];
    logic [DIV_W-1:0]  rem_in   [DIV_STAGES];
    logic [DIV_W-1:0]  den_in   [DIV_STAGES];
    logic [QUOT_W-1:0] quot_in  [DIV_STAGES];
    logic [DIV_W-1:0]  rem_next [DIV_STAGES];
    logic [QUOT_W-1:0] quot_next[DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign rem_in[s]  = num;
            assign den_in[s]  = den;
            assign quot_in[s] = '0;
        end
        else begin : g_rest
            assign rem_in[s]  = rem_reg[s-1];
            assign den_in[s]  = den_reg[s-1];
            assign quot_in[s] = quot_reg[s-1];
        end

        always_comb
        begin
            logic [DIV_W:0] trial;
            trial        = '0;
            rem_next[s]  = rem_in[s];
            quot_next[s] = quot_in[s];
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                if (s * DIV_STEPS + j < QUOT_W)
                begin
                    // The first step compares the numerator itself, later ones shift.
                    if (s * DIV_STEPS + j == 0)
                    begin
                        trial = {1'b0, rem_next[s]};
                    end
                    else
                    begin
                        trial = {rem_next[s], 1'b0};
                    end
                    if (trial >= {1'b0, den_in[s]})
                    begin
                        rem_next[s]  = DIV_W'(trial - {1'b0, den_in[s]});
                        quot_next[s] = {quot_next[s][QUOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[s]  = trial[DIV_W-1:0];
                        quot_next[s] = {quot_next[s][QUOT_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next[s];
                den_reg[s]  <= den_in[s];
                quot_reg[s] <= quot_next[s];
            end
        end
    end

    assign quot = quot_reg[DIV_STAGES-1];

endmodule

### design/rhr_analyze.sv
module rhr_analyze
    import rhr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            valid,
    input  logic [CH_W-1:0] red,
    input  logic [CH_W-1:0] green,
    input  logic [CH_W-1:0] blue,
    output logic            ana_valid,
    output ana_t            ana
);

    logic             valid_reg;
    ana_t             ana_reg;
    ana_t             ana_next;
    logic [CH_W-1:0]  mx;
    logic [CH_W-1:0]  mn;
    logic [CH_W-1:0]  d;
    logic [DIV_W-1:0] d6;
    logic             red_max;
    logic             green_max;

    always_comb
    begin
        red_max   = (red >= green) && (red >= blue);
        green_max = !red_max && (green >= blue);
        mx = red_max ? red : (green_max ? green : blue);
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        d  = mx - mn;
        d6 = DIV_W'({d, 2'b00}) + DIV_W'({d, 1'b0});

        ana_next.red     = red;
        ana_next.green   = green;
        ana_next.blue    = blue;
        ana_next.grey    = (mx == mn);
        ana_next.sum     = SUM_W'(mx) + SUM_W'(mn);
        ana_next.hue_den = d6;
        ana_next.sat_num = DIV_W'(d);
        // Saturation divides by the distance of the sum from the nearer end.
        if (ana_next.sum > SUM_W'(255))
        begin
            ana_next.sat_den = DIV_W'(SUM_W'(510) - ana_next.sum);
        end
        else
        begin
            ana_next.sat_den = DIV_W'(ana_next.sum);
        end
        // Hue numerator, kept in 0 .. 6d - 1.
        if (red_max)
        begin
            if (green >= blue)
            begin
                ana_next.hue_num = DIV_W'(green - blue);
            end
            else
            begin
                ana_next.hue_num = d6 - DIV_W'(blue - green);
            end
        end
        else if (green_max)
        begin
            ana_next.hue_num = DIV_W'({d, 1'b0}) + DIV_W'(blue) - DIV_W'(red);
        end
        else
        begin
            ana_next.hue_num = DIV_W'({d, 2'b00}) + DIV_W'(red) - DIV_W'(green);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ana_reg <= ana_next;
        end
    end

    assign ana_valid = valid_reg;
    assign ana       = ana_reg;

endmodule

### design/rhr_rebuild.sv
module rhr_rebuild
    import rhr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid,
    input  side_t             side,
    input  logic [QUOT_W-1:0] sat_quot,
    input  logic [QUOT_W-1:0] hue_quot,
    input  logic [FRAC_W-1:0] hue_step,
    output logic              out_valid,
    output logic [CH_W-1:0]   red,
    output logic [CH_W-1:0]   green,
    output logic [CH_W-1:0]   blue
);

    localparam int PQ_W   = FRAC_W + 3;
    localparam int F_W    = FRAC_W + 1;
    localparam int PROD_W = PQ_W + F_W + 1;
    localparam int V_W    = PQ_W + 3;
    localparam int W_W    = V_W + CH_W;

    typedef struct packed {
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic              grey;
        logic [FRAC_W-1:0] light;
        logic [FRAC_W-1:0] sat;
        logic [FRAC_W-1:0] hue;
        logic [FRAC_W-1:0] ls_hi;
    } stc_t;

    typedef struct packed {
        logic [CH_W-1:0]        red;
        logic [CH_W-1:0]        green;
        logic [CH_W-1:0]        blue;
        logic                   grey;
        logic signed [PQ_W-1:0] p;
        logic signed [PQ_W-1:0] diff;
        logic [2:0][F_W-1:0]    f;
    } std_t;

    typedef struct packed {
        logic [CH_W-1:0]               red;
        logic [CH_W-1:0]               green;
        logic [CH_W-1:0]               blue;
        logic                          grey;
        logic signed [PQ_W-1:0]        p;
        logic [2:0][PROD_W-1:0]        prod;
    } ste_t;

    // Weight of (q - p) for a channel hue t, in units of 1/65536.
    function automatic logic [F_W-1:0] hue_weight(input logic [FRAC_W-1:0] t);
        logic [FRAC_W+2:0] t6;
        logic [FRAC_W+1:0] t3;
        t6 = (FRAC_W+3)'({t, 2'b00}) + (FRAC_W+3)'({t, 1'b0});
        t3 = (FRAC_W+2)'({t, 1'b0}) + (FRAC_W+2)'(t);
        if (t6 < (FRAC_W+3)'(65536))
        begin
            hue_weight = t6[F_W-1:0];
        end
        else if (t < FRAC_W'(32768))
        begin
            hue_weight = F_W'(65536);
        end
        else if (t3 < (FRAC_W+2)'(131072))
        begin
            hue_weight = F_W'((FRAC_W+3)'(262144) - t6);
        end
        else
        begin
            hue_weight = '0;
        end
    endfunction

    function automatic logic [CH_W-1:0] to_byte(input logic signed [V_W-1:0] v);
        logic signed [W_W-1:0] w;
        logic signed [W_W-1:0] wa;
        logic signed [W_W-FRAC_W-1:0] c;
        w  = (W_W'(v) <<< CH_W) - W_W'(v);
        wa = w + (w[W_W-1] ? W_W'(65535) : W_W'(0));
        c  = wa[W_W-1:FRAC_W];
        if (c < 0)
        begin
            to_byte = '0;
        end
        else if (c > (W_W-FRAC_W)'(255))
        begin
            to_byte = '1;
        end
        else
        begin
            to_byte = c[CH_W-1:0];
        end
    endfunction

    logic              c_valid_reg, d_valid_reg, e_valid_reg, out_valid_reg;
    stc_t              c_reg, c_next;
    std_t              d_reg, d_next;
    ste_t              e_reg, e_next;
    logic [CH_W-1:0]   red_reg, green_reg, blue_reg;
    logic [CH_W-1:0]   red_next, green_next, blue_next;
    logic [2*FRAC_W-1:0] ls;
    logic signed [PQ_W-1:0] q;
    logic [2:0][FRAC_W-1:0] t;
    logic signed [PROD_W-1:0] pa;
    logic signed [PROD_W-FRAC_W-1:0] pq;
    logic signed [V_W-1:0] v;
    logic [2:0][CH_W-1:0] bytes;

    // Stage C: saturation clamp, hue rotation, L * S.
    always_comb
    begin
        c_next.red   = side.red;
        c_next.green = side.green;
        c_next.blue  = side.blue;
        c_next.grey  = side.grey;
        c_next.light = side.light;
        c_next.sat   = sat_quot[QUOT_W-1] ? '1 : sat_quot[FRAC_W-1:0];
        c_next.hue   = hue_quot[FRAC_W-1:0] + hue_step;
        ls           = c_next.light * c_next.sat;
        c_next.ls_hi = ls[2*FRAC_W-1:FRAC_W];
    end

    // Stage D: q, p and the three channel weights.
    always_comb
    begin
        if (c_reg.light < FRAC_W'(32768))
        begin
            q = PQ_W'(c_reg.light) + PQ_W'(c_reg.ls_hi);
        end
        else
        begin
            q = PQ_W'(c_reg.light) + PQ_W'(c_reg.sat) - PQ_W'(c_reg.ls_hi);
        end
        d_next.red   = c_reg.red;
        d_next.green = c_reg.green;
        d_next.blue  = c_reg.blue;
        d_next.grey  = c_reg.grey;
        d_next.p     = PQ_W'({c_reg.light, 1'b0}) - q;
        d_next.diff  = q - d_next.p;
        t[0] = c_reg.hue + THIRD_TURN;
        t[1] = c_reg.hue;
        t[2] = c_reg.hue - THIRD_TURN;
        for (int i = 0; i < 3; i++)
        begin
            d_next.f[i] = hue_weight(t[i]);
        end
    end

    // Stage E: the three products.
    always_comb
    begin
        e_next.red   = d_reg.red;
        e_next.green = d_reg.green;
        e_next.blue  = d_reg.blue;
        e_next.grey  = d_reg.grey;
        e_next.p     = d_reg.p;
        for (int i = 0; i < 3; i++)
        begin
            e_next.prod[i] = PROD_W'(PROD_W'(d_reg.diff) * PROD_W'($signed({1'b0, d_reg.f[i]})));
        end
    end

    // Stage F: value, scaling to a byte, grey bypass.
    always_comb
    begin
        pa = '0;
        pq = '0;
        v  = '0;
        for (int i = 0; i < 3; i++)
        begin
            pa = $signed(e_reg.prod[i]) + (e_reg.prod[i][PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
            pq = pa[PROD_W-1:FRAC_W];
            v  = V_W'(e_reg.p) + V_W'(pq);
            bytes[i] = to_byte(v);
        end
        if (e_reg.grey)
        begin
            red_next   = e_reg.red;
            green_next = e_reg.green;
            blue_next  = e_reg.blue;
        end
        else
        begin
            red_next   = bytes[0];
            green_next = bytes[1];
            blue_next  = bytes[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg   <= valid;
            d_valid_reg   <= c_valid_reg;
            e_valid_reg   <= d_valid_reg;
            out_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg     <= c_next;
            d_reg     <= d_next;
            e_reg     <= e_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

### design/rhr_checker.sv
module rhr_checker
    import rhr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [CH_W-1:0]   red_out,
    input logic [CH_W-1:0]   green_out,
    input logic [CH_W-1:0]   blue_out
);

    // A waiting item holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red_out) && $stable(green_out)
            && $stable(blue_out))
        else $error("output item changed while stalled");

    // A stalled output freezes the pipeline, so the input must stall too.
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while output stalled");

    // With the output empty the block never refuses an item.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // A new result appears only after the pipeline advanced.
    a_rise_moves: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_stall))
        else $error("result appeared without pipeline advance");

endmodule

bind rgb_hue_rotate_via_hsl_unit rhr_checker u_rhr_checker (.*);
